// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Condition in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: design/ps2hl_pkg.sv
package ps2hl_pkg;

  typedef enum logic [1:0] {
    ACT_EDGE    = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_QUEUE   = 2'd2,
    ACT_TAKE    = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_PREP_START    = 4'd1,
    PH_GET_BIT       = 4'd2,
    PH_GET_PARITY    = 4'd3,
    PH_GET_STOP      = 4'd4,
    PH_HOLDOFF       = 4'd5,
    PH_PREP_BIT      = 4'd6,
    PH_SEND_PARITY   = 4'd7,
    PH_SEND_STOP     = 4'd8,
    PH_WAIT_RESPONSE = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_FALL = 2'd1,
    EDGE_RISE = 2'd2
  } edge_e;

  typedef enum logic [1:0] {
    TMR_LEAVE   = 2'd0,
    TMR_RESTART = 2'd1,
    TMR_STOP    = 2'd2
  } timer_e;

  localparam int unsigned FrameBits = 8;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } ring_cmd_t;

  typedef struct packed {
    logic       full;
    logic       nonempty;
    logic       nonempty_next;
    logic [7:0] rd_data;
  } ring_stat_t;

  typedef struct packed {
    logic       drive_clk_low;
    logic       drive_data_low;
    edge_e      edge_wanted;
    timer_e     timer_cmd;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_overflow;
    logic       tx_accepted;
    logic       rx_available;
    logic       link_idle;
  } result_t;

endpackage

// File: design/ps2hl_ring.sv
// One-slot-empty circular byte buffer. Head = last written slot, tail = last
// read slot. The slot after the tail is prefetched into a register each cycle.
module ps2hl_ring
  import ps2hl_pkg::*;
#(
  parameter int unsigned AW = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ring_cmd_t  cmd_i,
  output ring_stat_t stat_o
);

  localparam int unsigned Depth = 1 << AW;

  logic [7:0]    mem [Depth];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_q;

  assign wr_addr = head_q + AW'(1);
  assign head_d  = cmd_i.push ? wr_addr : head_q;
  assign tail_d  = cmd_i.pop ? (tail_q + AW'(1)) : tail_q;
  assign rd_addr = tail_d + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= cmd_i.wdata;
    end
  end

  // write-first forward when the slot being written is the next one to read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (wr_addr == rd_addr)) begin
      rd_q <= cmd_i.wdata;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  assign stat_o.full          = (wr_addr == tail_q);
  assign stat_o.nonempty      = (head_q != tail_q);
  assign stat_o.nonempty_next = (head_d != tail_d);
  assign stat_o.rd_data       = rd_q;

endmodule

// File: design/ps2hl_core.sv
// Link phase sequencer: one event per step, state advances on step_i.
module ps2hl_core
  import ps2hl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  action_e    action_i,
  input  logic       data_level_i,
  input  logic       clk_level_i,
  input  logic [7:0] send_byte_i,
  input  ring_stat_t rx_stat_i,
  input  ring_stat_t tx_stat_i,
  output ring_cmd_t  rx_cmd_o,
  output ring_cmd_t  tx_cmd_o,
  output result_t    result_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bits_q, bits_d;
  logic       par_q, par_d;
  edge_e      edge_q, edge_d;
  logic       drv_clk_q, drv_clk_d;
  logic       drv_data_q, drv_data_d;

  timer_e     tmr;
  logic       ovf, acc, rv;
  logic [7:0] rb;
  logic       rx_push, rx_pop, tx_push, tx_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      shift_q    <= '0;
      bits_q     <= '0;
      par_q      <= 1'b0;
      edge_q     <= EDGE_FALL;
      drv_clk_q  <= 1'b0;
      drv_data_q <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      shift_q    <= shift_d;
      bits_q     <= bits_d;
      par_q      <= par_d;
      edge_q     <= edge_d;
      drv_clk_q  <= drv_clk_d;
      drv_data_q <= drv_data_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    par_d      = par_q;
    edge_d     = edge_q;
    drv_clk_d  = drv_clk_q;
    drv_data_d = drv_data_q;
    tmr        = TMR_LEAVE;
    ovf        = 1'b0;
    acc        = 1'b0;
    rv         = 1'b0;
    rb         = '0;
    rx_push    = 1'b0;
    rx_pop     = 1'b0;
    tx_push    = 1'b0;
    tx_pop     = 1'b0;

    unique case (action_i)
      ACT_EDGE: begin
        unique case (phase_q)
          PH_IDLE, PH_WAIT_RESPONSE: begin
            phase_d = PH_GET_BIT;
            shift_d = '0;
            bits_d  = '0;
            par_d   = 1'b0;
            tmr     = TMR_RESTART;
          end
          PH_GET_BIT: begin
            tmr     = TMR_RESTART;
            shift_d = {data_level_i, shift_q[7:1]};
            par_d   = par_q ^ data_level_i;
            bits_d  = bits_q + 4'd1;
            if (bits_d == 4'(FrameBits)) begin
              phase_d = PH_GET_PARITY;
            end
          end
          PH_GET_PARITY: begin
            tmr     = TMR_RESTART;
            phase_d = PH_GET_STOP;
          end
          PH_GET_STOP: begin
            tmr = TMR_STOP;
            if (rx_stat_i.full) begin
              ovf = 1'b1;
            end else begin
              rx_push = 1'b1;
            end
            phase_d = PH_HOLDOFF;
            edge_d  = EDGE_RISE;
          end
          PH_HOLDOFF: begin
            if (tx_stat_i.nonempty) begin
              phase_d   = PH_PREP_START;
              edge_d    = EDGE_NONE;
              drv_clk_d = 1'b1;
              tmr       = TMR_RESTART;
            end else begin
              phase_d = PH_IDLE;
              edge_d  = EDGE_FALL;
            end
          end
          PH_PREP_BIT: begin
            if (bits_q >= 4'(FrameBits)) begin
              // odd parity: line low when the data ones are already odd
              drv_data_d = par_q;
              phase_d    = PH_SEND_PARITY;
            end else begin
              drv_data_d = ~shift_q[0];
              par_d      = par_q ^ shift_q[0];
              shift_d    = {1'b0, shift_q[7:1]};
              bits_d     = bits_q + 4'd1;
            end
          end
          PH_SEND_PARITY: begin
            drv_data_d = 1'b0;
            phase_d    = PH_SEND_STOP;
          end
          PH_SEND_STOP: begin
            if (!data_level_i) begin
              tx_pop  = 1'b1;
              phase_d = PH_WAIT_RESPONSE;
              edge_d  = EDGE_FALL;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_TIMEOUT: begin
        tmr = TMR_STOP;
        unique case (phase_q)
          PH_GET_BIT, PH_GET_PARITY, PH_GET_STOP: begin
            if (tx_stat_i.nonempty) begin
              phase_d   = PH_PREP_START;
              edge_d    = EDGE_NONE;
              drv_clk_d = 1'b1;
              tmr       = TMR_RESTART;
            end else begin
              phase_d = PH_IDLE;
              edge_d  = EDGE_FALL;
            end
          end
          PH_PREP_START: begin
            drv_clk_d = 1'b0;
            edge_d    = EDGE_FALL;
            bits_d    = '0;
            par_d     = 1'b0;
            if (!clk_level_i) begin
              // device holds the clock: give up the line and receive
              drv_data_d = 1'b0;
              phase_d    = PH_GET_BIT;
              shift_d    = '0;
            end else begin
              drv_data_d = 1'b1;
              phase_d    = PH_PREP_BIT;
              shift_d    = tx_stat_i.rd_data;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_QUEUE: begin
        if (!tx_stat_i.full) begin
          tx_push = 1'b1;
          acc     = 1'b1;
          if (phase_q == PH_IDLE) begin
            phase_d   = PH_PREP_START;
            edge_d    = EDGE_NONE;
            drv_clk_d = 1'b1;
            tmr       = TMR_RESTART;
          end
        end
      end
      ACT_TAKE: begin
        if (rx_stat_i.nonempty) begin
          rx_pop = 1'b1;
          rb     = rx_stat_i.rd_data;
          rv     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rx_cmd_o.push  = rx_push & step_i;
  assign rx_cmd_o.pop   = rx_pop & step_i;
  assign rx_cmd_o.wdata = shift_q;
  assign tx_cmd_o.push  = tx_push & step_i;
  assign tx_cmd_o.pop   = tx_pop & step_i;
  assign tx_cmd_o.wdata = send_byte_i;

  assign result_o.drive_clk_low  = drv_clk_d;
  assign result_o.drive_data_low = drv_data_d;
  assign result_o.edge_wanted    = edge_d;
  assign result_o.timer_cmd      = tmr;
  assign result_o.rx_byte        = rb;
  assign result_o.rx_valid       = rv;
  assign result_o.rx_overflow    = ovf;
  assign result_o.tx_accepted    = acc;
  assign result_o.rx_available   = rx_stat_i.nonempty_next;
  assign result_o.link_idle      = (phase_d == PH_IDLE);

endmodule

// File: design/ps2_host_link_controller_unit.sv
// PS/2 host link controller.
// Input channel (in_valid_i/in_ready_o) carries one event per transaction:
// a clock edge of the wanted polarity, a 100 us timer expiry, a byte to queue
// for sending, or a request to take a received byte. The output channel
// (out_valid_o/out_ready_i) returns exactly one result per event: line
// drives, the edge to report next, a timer command and ring status.
// An accepted event waits in the input register and goes through the sequencer
// logic into the result register when the output is free. Throughput: one event
// per cycle while the output is not stalled, set by the single input register
// -> sequencer logic -> result register pass; ring reads come from a per-cycle
// prefetch of the slot after each tail. Reset: phase idle, falling edge wanted,
// both lines released, both rings empty. No clearing pass; ring storage is never read before it is written.
// When the receiver stalls, the result register holds; the input register
// still takes one more event and then ready drops until the result drains.
`include "assert_macros.svh"

module ps2_host_link_controller_unit
  import ps2hl_pkg::*;
#(
  parameter int unsigned RX_DEPTH_LOG2 = 4,
  parameter int unsigned TX_DEPTH_LOG2 = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic       data_level_i,
  input  logic       clk_level_i,
  input  logic [7:0] send_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       drive_clk_low_o,
  output logic       drive_data_low_o,
  output logic [1:0] edge_wanted_o,
  output logic [1:0] timer_cmd_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_valid_o,
  output logic       rx_overflow_o,
  output logic       tx_accepted_o,
  output logic       rx_available_o,
  output logic       link_idle_o
);

  // input register
  logic       in_vld_q;
  action_e    act_q;
  logic       data_q, clkl_q;
  logic [7:0] sbyte_q;

  // result register
  logic       out_vld_q;
  result_t    res_q, res_d;

  logic       step;
  ring_cmd_t  rx_cmd, tx_cmd;
  ring_stat_t rx_stat, tx_stat;

  // an event advances when the result register is empty or draining
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      act_q   <= action_e'(action_i);
      data_q  <= data_level_i;
      clkl_q  <= clk_level_i;
      sbyte_q <= send_byte_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  ps2hl_ring #(
    .AW(RX_DEPTH_LOG2)
  ) u_rx_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (rx_cmd),
    .stat_o(rx_stat)
  );

  ps2hl_ring #(
    .AW(TX_DEPTH_LOG2)
  ) u_tx_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (tx_cmd),
    .stat_o(tx_stat)
  );

  ps2hl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .action_i    (act_q),
    .data_level_i(data_q),
    .clk_level_i (clkl_q),
    .send_byte_i (sbyte_q),
    .rx_stat_i   (rx_stat),
    .tx_stat_i   (tx_stat),
    .rx_cmd_o    (rx_cmd),
    .tx_cmd_o    (tx_cmd),
    .result_o    (res_d)
  );

  assign out_valid_o      = out_vld_q;
  assign drive_clk_low_o  = res_q.drive_clk_low;
  assign drive_data_low_o = res_q.drive_data_low;
  assign edge_wanted_o    = res_q.edge_wanted;
  assign timer_cmd_o      = res_q.timer_cmd;
  assign rx_byte_o        = res_q.rx_byte;
  assign rx_valid_o       = res_q.rx_valid;
  assign rx_overflow_o    = res_q.rx_overflow;
  assign tx_accepted_o    = res_q.tx_accepted;
  assign rx_available_o   = res_q.rx_available;
  assign link_idle_o      = res_q.link_idle;

  // a stepped event always lands in the result register
  `ASSERT_NEXT(a_step_fills_out, clk_i, rst_ni, step, out_vld_q, "step lost result")
  // while the host holds CLK low no edge is watched
  `ASSERT_IMPL(a_clk_hold_no_edge, clk_i, rst_ni, out_vld_q && res_q.drive_clk_low,
               res_q.edge_wanted == EDGE_NONE, "edge wanted while clock held")
  // a dropped byte means the receive ring is full, so it is not empty
  `ASSERT_IMPL(a_ovf_avail, clk_i, rst_ni, out_vld_q && res_q.rx_overflow,
               res_q.rx_available, "overflow with empty receive ring")
  // a take is never reported by the same result as a queue or an overflow
  `ASSERT_IMPL(a_excl_flags, clk_i, rst_ni, out_vld_q && res_q.rx_valid,
               !res_q.tx_accepted && !res_q.rx_overflow, "mixed result flags")

endmodule

// File: tb/ps2_host_link_controller_unit_tb.sv
`default_nettype none

// Checks the PS/2 host link controller against a cycle-free prediction of its
// phase machine. Every event sent in is predicted when it is accepted, and the
// expected result waits in a queue until the block returns one. The generator
// looks at the predicted phase to pick the next event, so most traffic is
// well-formed frames, sends and acks. Noise and broken frames are mixed in.
module ps2_host_link_controller_unit_tb
  import ps2hl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RingSize   = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PrintCap   = 40;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Event channel into the block. All inputs start at known values.
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [1:0] action_i     = ACT_TAKE;
  logic       data_level_i = 1'b1;
  logic       clk_level_i  = 1'b1;
  logic [7:0] send_byte_i  = 8'h00;

  // Result channel out of the block.
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic       drive_clk_low_o;
  logic       drive_data_low_o;
  logic [1:0] edge_wanted_o;
  logic [1:0] timer_cmd_o;
  logic [7:0] rx_byte_o;
  logic       rx_valid_o;
  logic       rx_overflow_o;
  logic       tx_accepted_o;
  logic       rx_available_o;
  logic       link_idle_o;

  ps2_host_link_controller_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .data_level_i     (data_level_i),
    .clk_level_i      (clk_level_i),
    .send_byte_i      (send_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_clk_low_o  (drive_clk_low_o),
    .drive_data_low_o (drive_data_low_o),
    .edge_wanted_o    (edge_wanted_o),
    .timer_cmd_o      (timer_cmd_o),
    .rx_byte_o        (rx_byte_o),
    .rx_valid_o       (rx_valid_o),
    .rx_overflow_o    (rx_overflow_o),
    .tx_accepted_o    (tx_accepted_o),
    .rx_available_o   (rx_available_o),
    .link_idle_o      (link_idle_o)
  );

  // ---------------------------------------------------------------------------
  // Link state as the testbench believes it to be after every accepted event.
  // ---------------------------------------------------------------------------
  phase_e     ln_phase;
  logic [7:0] ln_shift;
  logic [3:0] ln_bits;
  logic       ln_parity;
  edge_e      ln_edge;
  logic       ln_drv_clk;
  logic       ln_drv_data;
  logic [7:0] rx_store [RingSize];
  logic [7:0] tx_store [RingSize];
  // Rings are one-slot-empty: the write pointer names the last slot written,
  // the read pointer the last slot read. 4-bit pointers wrap by themselves.
  logic [3:0] rx_wr, rx_rd, tx_wr, tx_rd;

  result_t     link_results[$];  // expected results, oldest first
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  function automatic void link_reset();
    ln_phase    = PH_IDLE;
    ln_shift    = 8'h00;
    ln_bits     = 4'd0;
    ln_parity   = 1'b0;
    ln_edge     = EDGE_FALL;
    ln_drv_clk  = 1'b0;
    ln_drv_data = 1'b0;
    rx_wr = 4'd0; rx_rd = 4'd0;
    tx_wr = 4'd0; tx_rd = 4'd0;
  endfunction

  // Host asks for the line: hold CLK low, ignore edges, start the 100 us wait.
  function automatic timer_e request_line();
    ln_phase   = PH_PREP_START;
    ln_edge    = EDGE_NONE;
    ln_drv_clk = 1'b1;
    return TMR_RESTART;
  endfunction

  // End of a received frame (or a receive timeout): send if anything queued.
  function automatic timer_e send_or_rest();
    if (tx_wr != tx_rd) return request_line();
    ln_phase = PH_IDLE;
    ln_edge  = EDGE_FALL;
    return TMR_STOP;
  endfunction

  function automatic result_t link_predict(action_e act, logic dl, logic cl,
                                           logic [7:0] sb);
    result_t    r;
    timer_e     tmr;
    logic [3:0] nxt;
    r   = '0;
    tmr = TMR_LEAVE;
    case (act)
      ACT_EDGE: begin
        case (ln_phase)
          PH_IDLE, PH_WAIT_RESPONSE: begin
            // start bit from the device
            ln_phase  = PH_GET_BIT;
            ln_shift  = 8'h00;
            ln_bits   = 4'd0;
            ln_parity = 1'b0;
            tmr       = TMR_RESTART;
          end
          PH_GET_BIT: begin
            tmr       = TMR_RESTART;
            ln_shift  = {dl, ln_shift[7:1]};
            ln_bits   = ln_bits + 4'd1;
            ln_parity = ln_parity ^ dl;
            if (ln_bits == 4'd8) ln_phase = PH_GET_PARITY;
          end
          PH_GET_PARITY: begin
            tmr      = TMR_RESTART;
            ln_phase = PH_GET_STOP;
          end
          PH_GET_STOP: begin
            tmr = TMR_STOP;
            nxt = rx_wr + 4'd1;
            if (nxt == rx_rd) begin
              r.rx_overflow = 1'b1;
            end else begin
              rx_store[nxt] = ln_shift;
              rx_wr         = nxt;
            end
            ln_phase = PH_HOLDOFF;
            ln_edge  = EDGE_RISE;
          end
          PH_HOLDOFF: begin
            tmr = send_or_rest();
            if (tmr == TMR_STOP) tmr = TMR_LEAVE;
          end
          PH_PREP_BIT: begin
            if (ln_bits >= 4'd8) begin
              ln_drv_data = ln_parity;  // odd parity: low when ones are odd
              ln_phase    = PH_SEND_PARITY;
            end else begin
              ln_drv_data = ~ln_shift[0];
              ln_parity   = ln_parity ^ ln_shift[0];
              ln_shift    = {1'b0, ln_shift[7:1]};
              ln_bits     = ln_bits + 4'd1;
            end
          end
          PH_SEND_PARITY: begin
            ln_drv_data = 1'b0;
            ln_phase    = PH_SEND_STOP;
          end
          PH_SEND_STOP: begin
            if (!dl) begin
              tx_rd    = tx_rd + 4'd1;
              ln_phase = PH_WAIT_RESPONSE;
              ln_edge  = EDGE_FALL;
            end
          end
          default: ;
        endcase
      end
      ACT_TIMEOUT: begin
        tmr = TMR_STOP;
        case (ln_phase)
          PH_GET_BIT, PH_GET_PARITY, PH_GET_STOP: tmr = send_or_rest();
          PH_PREP_START: begin
            ln_drv_clk = 1'b0;
            ln_edge    = EDGE_FALL;
            if (!cl) begin
              // device took the line first
              ln_drv_data = 1'b0;
              ln_phase    = PH_GET_BIT;
              ln_shift    = 8'h00;
              ln_bits     = 4'd0;
              ln_parity   = 1'b0;
            end else begin
              ln_drv_data = 1'b1;
              ln_phase    = PH_PREP_BIT;
              ln_bits     = 4'd0;
              ln_parity   = 1'b0;
              ln_shift    = tx_store[tx_rd + 4'd1];
            end
          end
          default: ;
        endcase
      end
      ACT_QUEUE: begin
        nxt = tx_wr + 4'd1;
        if (nxt != tx_rd) begin
          tx_store[nxt]  = sb;
          tx_wr          = nxt;
          r.tx_accepted  = 1'b1;
          if (ln_phase == PH_IDLE) tmr = request_line();
        end
      end
      default: begin
        if (rx_wr != rx_rd) begin
          rx_rd      = rx_rd + 4'd1;
          r.rx_byte  = rx_store[rx_rd];
          r.rx_valid = 1'b1;
        end
      end
    endcase
    r.drive_clk_low  = ln_drv_clk;
    r.drive_data_low = ln_drv_data;
    r.edge_wanted    = ln_edge;
    r.timer_cmd      = tmr;
    r.rx_available   = (rx_wr != rx_rd);
    r.link_idle      = (ln_phase == PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Bursts of random length with random gaps; inputs move on the
  // falling edge, acceptance is seen at the rising edge.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_event(action_e act, logic dl, logic cl, logic [7:0] sb);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    action_i     <= act;
    data_level_i <= dl;
    clk_level_i  <= cl;
    send_byte_i  <= sb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    link_results.push_back(link_predict(act, dl, cl, sb));
  endtask

  function automatic logic rbit();
    return logic'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rbyte();
    return 8'($urandom);
  endfunction

  // Sender holds off until every expected result is back.
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (link_results.size() != 0) @(posedge clk_i);
  endtask

  // Walk the link back to idle with an empty transmit ring, acking every send.
  task automatic settle_link();
    while (ln_phase != PH_IDLE || tx_wr != tx_rd) begin
      case (ln_phase)
        PH_PREP_START: send_event(ACT_TIMEOUT, rbit(), 1'b1, rbyte());
        PH_GET_BIT, PH_GET_PARITY, PH_GET_STOP:
          send_event(ACT_TIMEOUT, rbit(), rbit(), rbyte());
        PH_SEND_STOP: send_event(ACT_EDGE, 1'b0, rbit(), rbyte());
        default: send_event(ACT_EDGE, rbit(), rbit(), rbyte());
      endcase
    end
  endtask

  // Full device-to-host frame from idle: start, 8 data bits, parity, stop,
  // then the rising edge that ends the hold-off.
  task automatic receive_frame(logic [7:0] value);
    send_event(ACT_EDGE, 1'b0, rbit(), rbyte());
    for (int i = 0; i < 8; i++) send_event(ACT_EDGE, value[i], rbit(), rbyte());
    send_event(ACT_EDGE, rbit(), rbit(), rbyte());
    send_event(ACT_EDGE, 1'b1, rbit(), rbyte());
    send_event(ACT_EDGE, rbit(), rbit(), rbyte());
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // All-ones frame in, read it out, then take from an empty ring.
  task automatic test_rx_frame();
    receive_frame(8'hFF);
    send_event(ACT_TAKE, 1'b0, 1'b0, 8'hFF);
    send_event(ACT_TAKE, 1'b1, 1'b1, 8'h00);
  endtask

  // All-zeros byte out: clock inhibit, start, data, parity, stop, a missing
  // ack (DATA still high) and then the real ack.
  task automatic test_tx_frame();
    send_event(ACT_QUEUE, 1'b1, 1'b1, 8'h00);
    send_event(ACT_TIMEOUT, 1'b1, 1'b1, 8'h00);
    for (int i = 0; i < 9; i++) send_event(ACT_EDGE, rbit(), 1'b0, 8'h00);
    send_event(ACT_EDGE, 1'b1, 1'b0, 8'h00);
    send_event(ACT_EDGE, 1'b1, 1'b1, 8'h00);
    send_event(ACT_EDGE, 1'b0, 1'b1, 8'h00);
  endtask

  // Queue while busy, receive timeouts both ways, a stray edge while the
  // clock is inhibited, and the device grabbing the line at the inhibit end.
  task automatic test_line_contention();
    send_event(ACT_QUEUE, 1'b0, 1'b0, 8'h5A);     // waiting on the response
    send_event(ACT_EDGE, 1'b0, 1'b0, 8'h00);      // device starts a frame
    send_event(ACT_EDGE, 1'b1, 1'b0, 8'h00);
    send_event(ACT_TIMEOUT, 1'b0, 1'b1, 8'h00);   // timeout, byte is queued
    send_event(ACT_EDGE, 1'b0, 1'b1, 8'h00);      // not wanted now
    send_event(ACT_TIMEOUT, 1'b1, 1'b0, 8'h00);   // CLK low: device wins
    send_event(ACT_TIMEOUT, 1'b0, 1'b0, 8'h00);
    settle_link();
    send_event(ACT_TIMEOUT, 1'b1, 1'b1, 8'h00);   // idle, only stops timer
    send_event(ACT_EDGE, 1'b0, 1'b0, 8'h00);
    send_event(ACT_TIMEOUT, 1'b0, 1'b0, 8'h00);   // timeout, nothing queued
  endtask

  // Sixteen frames into a ring that holds fifteen, then read everything back.
  task automatic test_rx_overflow();
    settle_link();
    while (rx_wr != rx_rd) send_event(ACT_TAKE, rbit(), rbit(), rbyte());
    for (int i = 0; i < RingSize; i++) receive_frame(rbyte());
    for (int i = 0; i < RingSize; i++) send_event(ACT_TAKE, rbit(), rbit(), rbyte());
  endtask

  // Sixteen bytes into the transmit ring: the last is refused. Then send all.
  task automatic test_tx_full();
    settle_link();
    send_event(ACT_QUEUE, rbit(), rbit(), 8'hFF);
    for (int i = 1; i < RingSize; i++) send_event(ACT_QUEUE, rbit(), rbit(), rbyte());
    settle_link();
  endtask

  // One event picked from the current phase: mostly what a real link would
  // produce next, with some noise.
  task automatic random_event();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      send_event(action_e'($urandom_range(0, 3)), rbit(), rbit(), rbyte());
      return;
    end
    pick = $urandom_range(0, 99);
    case (ln_phase)
      PH_IDLE: begin
        if (pick < 40)      send_event(ACT_EDGE, rbit(), rbit(), rbyte());
        else if (pick < 60) send_event(ACT_QUEUE, rbit(), rbit(), rbyte());
        else if (pick < 90) send_event(ACT_TAKE, rbit(), rbit(), rbyte());
        else                send_event(ACT_TIMEOUT, rbit(), rbit(), rbyte());
      end
      PH_PREP_START: begin
        if (pick < 75)      send_event(ACT_TIMEOUT, rbit(), 1'b1, rbyte());
        else if (pick < 88) send_event(ACT_TIMEOUT, rbit(), 1'b0, rbyte());
        else if (pick < 94) send_event(ACT_EDGE, rbit(), rbit(), rbyte());
        else                send_event(ACT_QUEUE, rbit(), rbit(), rbyte());
      end
      PH_GET_BIT, PH_GET_PARITY, PH_GET_STOP: begin
        if (pick < 88)      send_event(ACT_EDGE, rbit(), rbit(), rbyte());
        else if (pick < 92) send_event(ACT_TIMEOUT, rbit(), rbit(), rbyte());
        else if (pick < 96) send_event(ACT_TAKE, rbit(), rbit(), rbyte());
        else                send_event(ACT_QUEUE, rbit(), rbit(), rbyte());
      end
      PH_SEND_STOP: begin
        if (pick < 70)      send_event(ACT_EDGE, 1'b0, rbit(), rbyte());
        else if (pick < 88) send_event(ACT_EDGE, 1'b1, rbit(), rbyte());
        else                send_event(ACT_TAKE, rbit(), rbit(), rbyte());
      end
      PH_WAIT_RESPONSE: begin
        if (pick < 70)      send_event(ACT_EDGE, rbit(), rbit(), rbyte());
        else if (pick < 80) send_event(ACT_TIMEOUT, rbit(), rbit(), rbyte());
        else if (pick < 90) send_event(ACT_QUEUE, rbit(), rbit(), rbyte());
        else                send_event(ACT_TAKE, rbit(), rbit(), rbyte());
      end
      default: begin  // hold-off and the sending phases just want edges
        if (pick < 88)      send_event(ACT_EDGE, rbit(), rbit(), rbyte());
        else if (pick < 94) send_event(ACT_TAKE, rbit(), rbit(), rbyte());
        else                send_event(ACT_QUEUE, rbit(), rbit(), rbyte());
      end
    endcase
  endtask

  task automatic test_random_traffic(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      random_event();
      if (i == count / 2) hold_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: the stall pattern switches at random between always ready,
  // coin flip, a fixed duty pattern and occasional long stalls.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned stall_left = 0;
  int unsigned pace_count = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 200);
    end
    mode_left--;
    pace_count++;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= rbit();
      2: out_ready_i <= (pace_count % 5 != 0) && (pace_count % 7 != 3);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(5, 20);
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checking: every returned transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PrintCap) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (link_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = link_results.pop_front();
        check_field("drive_clk_low", 8'(want.drive_clk_low), 8'(drive_clk_low_o));
        check_field("drive_data_low", 8'(want.drive_data_low), 8'(drive_data_low_o));
        check_field("edge_wanted", 8'(want.edge_wanted), 8'(edge_wanted_o));
        check_field("timer_cmd", 8'(want.timer_cmd), 8'(timer_cmd_o));
        check_field("rx_byte", want.rx_byte, rx_byte_o);
        check_field("rx_valid", 8'(want.rx_valid), 8'(rx_valid_o));
        check_field("rx_overflow", 8'(want.rx_overflow), 8'(rx_overflow_o));
        check_field("tx_accepted", 8'(want.tx_accepted), 8'(tx_accepted_o));
        check_field("rx_available", 8'(want.rx_available), 8'(rx_available_o));
        check_field("link_idle", 8'(want.link_idle), 8'(link_idle_o));
      end
    end
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("ps2_host_link_controller_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    link_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_rx_frame();
    test_tx_frame();
    test_line_contention();
    test_rx_overflow();
    test_tx_full();
    // directed tests above already send close to 500 events
    test_random_traffic(40);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (link_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && link_results.size() == 0) begin
      $display("ps2_host_link_controller_unit regression: pass");
    end else begin
      $display("ps2_host_link_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
